@@ rtl/chf_pkg.sv @@
// ----------------------------------------------------------------------------
// chf_pkg
// Types and constants shared by the compass heading pipeline.
// ----------------------------------------------------------------------------
package chf_pkg;

  localparam int XW        = 28;  // CORDIC x/y datapath width
  localparam int ZW        = 20;  // CORDIC angle width, radians * 65536
  localparam int HW        = 21;  // heading sum width before wrap
  localparam int WW        = 19;  // wrapped heading width, 0..2*pi
  localparam int PW        = 47;  // product width for degree conversion
  localparam int TABLE_LEN = 24;

  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    ang_t                 z;
    logic                 zero;
  } cordic_t;

  localparam ang_t ANG_PI = 20'sd205887;
  localparam logic signed [HW-1:0] ANG_TWO_PI = 21'sd411775;
  localparam logic [27:0] DEG64_MUL = 28'd240315917;
  localparam logic [14:0] HEADING_MAX = 15'd23040;

  localparam ang_t ATAN_TAB [TABLE_LEN] = '{
    20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2,    20'sd1,    20'sd0,
    20'sd0,     20'sd0,     20'sd0,     20'sd0,    20'sd0,    20'sd0
  };

  typedef enum logic [1:0] {
    CFG_X_OFFSET    = 2'd0,
    CFG_Y_OFFSET    = 2'd1,
    CFG_DECLINATION = 2'd2
  } cfg_idx_t;

endpackage

@@ rtl/chf_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// chf_cordic_stage
// One registered vectoring CORDIC micro-rotation with its own valid bit.
// ----------------------------------------------------------------------------
module chf_cordic_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  chf_pkg::cordic_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output chf_pkg::cordic_t dn_data
);
  import chf_pkg::*;

  logic    valid_r;
  cordic_t data_r;
  cordic_t data_nxt;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    xs = up_data.x >>> STAGE;
    ys = up_data.y >>> STAGE;
    data_nxt = up_data;
    if (!up_data.y[XW-1]) begin
      data_nxt.x = up_data.x + ys;
      data_nxt.y = up_data.y - xs;
      data_nxt.z = up_data.z + ATAN_TAB[STAGE];
    end else begin
      data_nxt.x = up_data.x - ys;
      data_nxt.y = up_data.y + xs;
      data_nxt.z = up_data.z - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ rtl/compass_heading_from_field.sv @@
// ----------------------------------------------------------------------------
// compass_heading_from_field
// Magnetometer X/Y sample to compass heading: offset removal, CORDIC atan2,
// declination, wrap to one turn, conversion to degrees * 64.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the output is not stalled;
// each CORDIC iteration is its own stage.
// Every stage holds its own valid bit, so a stalled output fills bubbles first.
// Reset clears all valid bits and the offset and declination registers to 0.
// ----------------------------------------------------------------------------
module compass_heading_from_field #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] x_axis, [31:16] y_axis
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] heading_deg, degrees * 64; [15] reserved, reads 0
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import chf_pkg::*;

  localparam int N = CORDIC_ITERATIONS;

  logic [15:0] x_offset_r;
  logic [15:0] y_offset_r;
  logic [15:0] declination_r;

  logic    c_vld [N+1];
  logic    c_rdy [N+1];
  cordic_t c_bus [N+1];

  logic    prep_vld_r;
  cordic_t prep_r;
  cordic_t prep_nxt;

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] xa;
  logic signed [16:0] ya;

  logic                 w1_vld_r;
  logic                 w1_rdy;
  logic signed [HW-1:0] h1_r;
  logic signed [HW-1:0] h1_nxt;
  ang_t                 z_eff;

  logic                 w2_vld_r;
  logic                 w2_rdy;
  logic [WW-1:0]        hw_r;
  logic [WW-1:0]        hw_nxt;
  logic signed [HW-1:0] ha;
  logic signed [HW-1:0] hb;

  logic          m_vld_r;
  logic          m_rdy;
  logic [PW-1:0] prod_r;
  logic [PW-1:0] prod_nxt;

  logic          out_vld_r;
  logic          out_rdy;
  logic [14:0]   heading_r;
  logic [14:0]   heading_nxt;
  logic [PW:0]   rnd;
  logic [15:0]   deg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r    <= '0;
      y_offset_r    <= '0;
      declination_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_OFFSET:    x_offset_r    <= cfg_wdata;
        CFG_Y_OFFSET:    y_offset_r    <= cfg_wdata;
        CFG_DECLINATION: declination_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // prep stage: remove offsets, fold negative X into the right half plane
  always_comb begin
    dx = {in_tdata[15], in_tdata[15:0]} - {x_offset_r[15], x_offset_r};
    dy = {in_tdata[31], in_tdata[31:16]} - {y_offset_r[15], y_offset_r};
    xa = dx[16] ? -dx : dx;
    ya = dx[16] ? -dy : dy;
    prep_nxt.x    = {{(XW-25){xa[16]}}, xa, 8'h00};
    prep_nxt.y    = {{(XW-25){ya[16]}}, ya, 8'h00};
    prep_nxt.z    = dx[16] ? (dy[16] ? -ANG_PI : ANG_PI) : '0;
    prep_nxt.zero = (dx == '0) && (dy == '0);
  end

  assign in_tready = !prep_vld_r || c_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (in_tready) begin
      prep_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      prep_r <= prep_nxt;
    end
  end

  assign c_vld[0] = prep_vld_r;
  assign c_bus[0] = prep_r;
  assign c_rdy[N] = w1_rdy;

  for (genvar k = 0; k < N; k++) begin : g_cordic
    chf_cordic_stage #(
      .STAGE (k)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_vld[k]),
      .up_ready (c_rdy[k]),
      .up_data  (c_bus[k]),
      .dn_valid (c_vld[k+1]),
      .dn_ready (c_rdy[k+1]),
      .dn_data  (c_bus[k+1])
    );
  end

  // add declination
  assign z_eff  = c_bus[N].zero ? '0 : c_bus[N].z;
  assign h1_nxt = {z_eff[ZW-1], z_eff} +
                  {{(HW-19){declination_r[15]}}, declination_r, 3'b000};
  assign w1_rdy = !w1_vld_r || w2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_vld_r <= 1'b0;
    end else if (w1_rdy) begin
      w1_vld_r <= c_vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (w1_rdy && c_vld[N]) begin
      h1_r <= h1_nxt;
    end
  end

  // wrap once into one turn, clamp what stays negative
  always_comb begin
    ha = h1_r[HW-1] ? h1_r + ANG_TWO_PI : h1_r;
    hb = (ha > ANG_TWO_PI) ? ha - ANG_TWO_PI : ha;
    hw_nxt = hb[HW-1] ? '0 : hb[WW-1:0];
  end

  assign w2_rdy = !w2_vld_r || m_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w2_vld_r <= 1'b0;
    end else if (w2_rdy) begin
      w2_vld_r <= w1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (w2_rdy && w1_vld_r) begin
      hw_r <= hw_nxt;
    end
  end

  // scale to degrees * 64
  assign prod_nxt = PW'(hw_r) * PW'(DEG64_MUL);
  assign m_rdy    = !m_vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (m_rdy) begin
      m_vld_r <= w2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy && w2_vld_r) begin
      prod_r <= prod_nxt;
    end
  end

  // round, saturate, output register
  always_comb begin
    rnd = {1'b0, prod_r} + (PW+1)'(33'h0_8000_0000);
    deg = rnd[PW:32];
    heading_nxt = (deg > {1'b0, HEADING_MAX}) ? HEADING_MAX : deg[14:0];
  end

  assign out_rdy = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && m_vld_r) begin
      heading_r <= heading_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, heading_r};

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:0] <= HEADING_MAX))
    else $error("heading above full turn");

  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    w2_vld_r |-> ($signed({2'b00, hw_r}) <= ANG_TWO_PI))
    else $error("wrapped angle outside one turn");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  a_mult_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (m_vld_r && !out_rdy) |=> (m_vld_r && $stable(prod_r)))
    else $error("product stage lost data under stall");

endmodule
